@@ design/esrr_pkg.sv @@
// Package for the expiring-slot round-robin scheduler.
// Holds the table size, time constants, opcodes, status codes and the structs
// shared by the controller, the datapath and the top level. No dependencies.
package esrr_pkg;

	localparam int unsigned SLOT_COUNT = 16;
	localparam int unsigned SW         = $clog2(SLOT_COUNT);
	localparam int unsigned CNT_W      = (SW > 4) ? SW : 4;
	localparam int unsigned DIV_STEPS  = 4;
	localparam int unsigned US_PER_MS  = 1000;

	localparam logic [62:0] TIME_MAX = {63{1'b1}};
	// A difference at or above this gives a quotient that no longer fits 32 bits.
	localparam logic [62:0] SAT_DIFF = 63'(US_PER_MS) << 32;
	// The fraction 0.024 of 1024/1000, scaled by 2^32 and rounded down.
	localparam logic [26:0] MS_RECIP = 27'd103079215;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_FULL     = 3'd1,
		ST_REMOVED  = 3'd2,
		ST_SELECTED = 3'd3,
		ST_NONE     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_MUL,
		S_ADDW,
		S_EXP,
		S_EXPW,
		S_PICK,
		S_SUB,
		S_DIVI,
		S_DIV,
		S_RES
	} state_t;

	typedef struct packed {
		op_t         opcode;
		logic [62:0] now_us;
		logic        hold;
		logic [7:0]  cmd_kind;
		logic [31:0] life_ms;
		logic [31:0] prep_ms;
		logic [63:0] target_bits;
		logic [23:0] extra_bytes;
		logic [7:0]  slot_sel;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  slot_no;
		logic [31:0] left_ms;
		logic [7:0]  out_kind;
		logic [31:0] out_prep_ms;
		logic [63:0] out_target;
		logic [23:0] out_extra;
	} res_t;

	typedef struct packed {
		logic [62:0] end_time;
		logic [7:0]  kind;
		logic [31:0] prep;
		logic [63:0] target;
		logic [23:0] extra;
	} slot_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic add_wr;
		logic remove;
		logic none;
		logic exp_rd;
		logic pick;
		logic sub;
		logic div_init;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic hold;
		logic cnt_last;
		logic div_last;
		logic any_valid;
		logic sat;
	} dp_sts_t;

	// Slot numbers are reported in four bits: the low bits of the index.
	function automatic logic [3:0] to_slot_no(input logic [SW-1:0] idx);
		logic [SW+3:0] ext;
		ext = {4'b0, idx};
		return ext[3:0];
	endfunction

endpackage

@@ design/esrr_item_if.sv @@
// Input channel of the scheduler: valid/ready handshake and one item's fields.
// Depends on nothing.
interface esrr_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [62:0] now_us;
	logic        hold;
	logic [7:0]  cmd_kind;
	logic [31:0] life_ms;
	logic [31:0] prep_ms;
	logic [63:0] target_bits;
	logic [23:0] extra_bytes;
	logic [7:0]  slot_sel;

	modport source (
		output valid, opcode, now_us, hold, cmd_kind, life_ms, prep_ms,
		       target_bits, extra_bytes, slot_sel,
		input  ready
	);
	modport sink (
		input  valid, opcode, now_us, hold, cmd_kind, life_ms, prep_ms,
		       target_bits, extra_bytes, slot_sel,
		output ready
	);
endinterface

@@ design/esrr_result_if.sv @@
// Output channel of the scheduler: valid/ready handshake and one result's fields.
// Depends on nothing.
interface esrr_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  slot_no;
	logic [31:0] left_ms;
	logic [7:0]  out_kind;
	logic [31:0] out_prep_ms;
	logic [63:0] out_target;
	logic [23:0] out_extra;

	modport source (
		output valid, status, slot_no, left_ms, out_kind, out_prep_ms,
		       out_target, out_extra,
		input  ready
	);
	modport sink (
		input  valid, status, slot_no, left_ms, out_kind, out_prep_ms,
		       out_target, out_extra,
		output ready
	);
endinterface

@@ design/esrr_ctrl.sv @@
// Controller of the scheduler: sequences add, remove and tick work on the datapath.
// Depends on esrr_pkg.
module esrr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_free,
	input  esrr_pkg::dp_sts_t st,
	output logic              in_ready,
	output esrr_pkg::dp_cmd_t cmd
);
	import esrr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				case (st.op)
					OP_ADD: state_d = S_MUL;
					OP_REMOVE: begin
						cmd.remove = 1'b1;
						state_d    = S_RES;
					end
					OP_TICK: begin
						if (st.hold) begin
							cmd.none = 1'b1;
							state_d  = S_RES;
						end else begin
							state_d = S_EXP;
						end
					end
					default: begin
						cmd.none = 1'b1;
						state_d  = S_RES;
					end
				endcase
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADDW;
			end
			S_ADDW: begin
				cmd.add_wr = 1'b1;
				state_d    = S_RES;
			end
			S_EXP: begin
				cmd.exp_rd = 1'b1;
				if (st.cnt_last) begin
					state_d = S_EXPW;
				end
			end
			// The last slot's end time is checked here.
			S_EXPW: state_d = S_PICK;
			S_PICK: begin
				cmd.pick = 1'b1;
				if (st.any_valid) begin
					state_d = S_SUB;
				end else begin
					cmd.none = 1'b1;
					state_d  = S_RES;
				end
			end
			S_SUB: begin
				cmd.sub = 1'b1;
				state_d = S_DIVI;
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				state_d      = st.sat ? S_RES : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_RES;
				end
			end
			S_RES: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	ap_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_free && state_q == S_RES)
		else $error("result loaded while the output register is occupied");

	ap_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && st.div_last |=> state_q == S_RES)
		else $error("division did not hand over to the result state");

	ap_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_DEC)
		else $error("accepted item not decoded");

endmodule

@@ design/esrr_dp.sv @@
// Datapath of the scheduler: slot memory, valid bits, round-robin pointer,
// end-time arithmetic and a reciprocal-multiply divide by 1000. Depends on esrr_pkg.
module esrr_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  esrr_pkg::item_t   item_d,
	input  esrr_pkg::dp_cmd_t cmd,
	output esrr_pkg::dp_sts_t st,
	output esrr_pkg::res_t    out_q
);
	import esrr_pkg::*;

	item_t             in_q;
	logic [SLOT_COUNT-1:0] valid_q;
	logic [SW-1:0]     rr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              chk_v_s1;
	logic [SW-1:0]     chk_idx_s1;
	logic [41:0]       prod_q;
	logic [62:0]       diff_q;
	logic [58:0]       recip_q;
	logic [41:0]       mprod_q;
	logic [11:0]       rem_q;
	logic [31:0]       dq_q;
	res_t              res_q;

	slot_t             mem [SLOT_COUNT];
	slot_t             rd_q;
	slot_t             wdata;
	logic              mem_we;
	logic [SW-1:0]     raddr;

	logic [SW-1:0]     free_idx;
	logic              full;
	logic [SW-1:0]     pick_idx;
	logic [SW-1:0]     rr_next;
	logic [63:0]       end_sum;
	logic [62:0]       end_time;
	logic [1:0]        q_fix;
	logic              remove_hit;

	function automatic res_t mk_res(input status_t s, input logic [3:0] n);
		res_t r;
		r         = '0;
		r.status  = s;
		r.slot_no = n;
		return r;
	endfunction

	// Lowest free slot.
	always_comb begin
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = SW'(i);
			end
		end
	end
	assign full = &valid_q;

	// First valid slot at or after the round-robin pointer.
	always_comb begin
		logic [SW:0] sum;
		pick_idx = '0;
		for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
			sum = {1'b0, rr_q} + (SW+1)'(k);
			if (sum >= (SW+1)'(SLOT_COUNT)) begin
				sum = sum - (SW+1)'(SLOT_COUNT);
			end
			if (valid_q[sum[SW-1:0]]) begin
				pick_idx = sum[SW-1:0];
			end
		end
	end
	assign rr_next = (pick_idx == SW'(SLOT_COUNT - 1)) ? '0 : pick_idx + 1'b1;

	// now + delay*1000 cannot pass 2^64, so bit 63 marks the saturating case.
	assign end_sum  = {1'b0, in_q.now_us} + {22'b0, prod_q};
	assign end_time = end_sum[63] ? TIME_MAX : end_sum[62:0];

	assign wdata.end_time = end_time;
	assign wdata.kind     = in_q.cmd_kind;
	assign wdata.prep     = in_q.prep_ms;
	assign wdata.target   = in_q.target_bits;
	assign wdata.extra    = in_q.extra_bytes;
	assign mem_we         = cmd.add_wr && !full;
	assign raddr          = cmd.pick ? pick_idx : cnt_q[SW-1:0];

	// The estimated quotient is at most two low, so the remainder is under 3000.
	assign q_fix = (rem_q >= 12'(2 * US_PER_MS)) ? 2'd2 :
	               (rem_q >= 12'(US_PER_MS))     ? 2'd1 : 2'd0;

	assign remove_hit = in_q.slot_sel < 8'(SLOT_COUNT);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[free_idx] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rr_q     <= '0;
			cnt_q    <= '0;
			chk_v_s1 <= 1'b0;
		end else begin
			chk_v_s1 <= cmd.exp_rd;
			if (cmd.exp_rd) begin
				cnt_q <= st.cnt_last ? '0 : cnt_q + 1'b1;
			end else if (cmd.div_step) begin
				cnt_q <= st.div_last ? '0 : cnt_q + 1'b1;
			end
			if (mem_we) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (cmd.remove && remove_hit) begin
				valid_q[in_q.slot_sel[SW-1:0]] <= 1'b0;
			end
			if (chk_v_s1 && in_q.now_us >= rd_q.end_time) begin
				valid_q[chk_idx_s1] <= 1'b0;
			end
			if (cmd.pick && st.any_valid) begin
				rr_q <= rr_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= cnt_q[SW-1:0];
		if (cmd.capture) begin
			in_q <= item_d;
		end
		if (cmd.mul) begin
			prod_q <= 42'(in_q.life_ms) * 42'(US_PER_MS);
		end
		if (cmd.add_wr) begin
			res_q <= full ? mk_res(ST_FULL, 4'd0) : mk_res(ST_ADDED, to_slot_no(free_idx));
		end
		if (cmd.remove) begin
			res_q <= mk_res(ST_REMOVED, 4'd0);
		end
		if (cmd.none) begin
			res_q <= mk_res(ST_NONE, 4'd0);
		end else if (cmd.pick) begin
			res_q <= mk_res(ST_SELECTED, to_slot_no(pick_idx));
		end
		if (cmd.sub) begin
			diff_q            <= rd_q.end_time - in_q.now_us;
			res_q.out_kind    <= rd_q.kind;
			res_q.out_prep_ms <= rd_q.prep;
			res_q.out_target  <= rd_q.target;
			res_q.out_extra   <= rd_q.extra;
		end
		if (cmd.div_init) begin
			// With t = diff >> 10, diff / 1000 is close to t + t * 0.024.
			recip_q <= 59'(diff_q[41:10]) * 59'(MS_RECIP);
			if (st.sat) begin
				res_q.left_ms <= '1;
			end
		end
		if (cmd.div_step) begin
			// Each register reads the one before it, so step k settles stage k.
			dq_q    <= diff_q[41:10] + 32'(recip_q[58:32]);
			mprod_q <= 42'(dq_q) * 42'(US_PER_MS);
			rem_q   <= 12'(diff_q[41:0] - mprod_q);
			if (st.div_last) begin
				res_q.left_ms <= dq_q + 32'(q_fix);
			end
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign st.op        = in_q.opcode;
	assign st.hold      = in_q.hold;
	assign st.cnt_last  = cnt_q == CNT_W'(SLOT_COUNT - 1);
	assign st.div_last  = cnt_q == CNT_W'(DIV_STEPS - 1);
	assign st.any_valid = |valid_q;
	assign st.sat       = diff_q >= SAT_DIFF;

	ap_remove_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.remove && remove_hit |=> !valid_q[$past(in_q.slot_sel[SW-1:0])])
		else $error("removed slot still valid");

	ap_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> $countones(valid_q) == $past($countones(valid_q)) + 1)
		else $error("add did not occupy exactly one new slot");

	ap_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && st.div_last |-> rem_q < 12'(3 * US_PER_MS))
		else $error("divider remainder out of range");

	ap_pick_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pick && st.any_valid |-> valid_q[pick_idx])
		else $error("round-robin pick landed on a free slot");

endmodule

@@ design/expiring_slot_round_robin_scheduler.sv @@
// Expiring-slot round-robin scheduler, top level: handshakes and output register.
// Remove, held tick and opcode 3 pass IDLE, DEC, RES; add passes IDLE, DEC, MUL, ADDW, RES;
// a tick scans in EXP and EXPW, one slot per cycle, then PICK leads to RES with no slot to
// select, else SUB, DIVI and DIV divide by 1000 before RES (DIVI to RES when the remainder
// saturates). One item is in work at a time; a result not yet taken holds the block in RES.
// Reset (arst_n, asynchronous) frees all slots and clears the round-robin pointer.
module expiring_slot_round_robin_scheduler (
	input  logic clk,
	input  logic arst_n,
	esrr_item_if.sink     item,
	esrr_result_if.source result
);
	import esrr_pkg::*;

	item_t   item_d;
	dp_cmd_t cmd;
	dp_sts_t st;
	res_t    out_q;
	logic    out_valid_q;
	logic    out_free;
	logic    in_ready;

	assign item_d.opcode      = op_t'(item.opcode);
	assign item_d.now_us      = item.now_us;
	assign item_d.hold        = item.hold;
	assign item_d.cmd_kind    = item.cmd_kind;
	assign item_d.life_ms     = item.life_ms;
	assign item_d.prep_ms     = item.prep_ms;
	assign item_d.target_bits = item.target_bits;
	assign item_d.extra_bytes = item.extra_bytes;
	assign item_d.slot_sel    = item.slot_sel;

	assign out_free   = !out_valid_q || result.ready;
	assign item.ready = in_ready;

	esrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.out_free (out_free),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	esrr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item_d (item_d),
		.cmd    (cmd),
		.st     (st),
		.out_q  (out_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.status      = out_q.status;
	assign result.slot_no     = out_q.slot_no;
	assign result.left_ms     = out_q.left_ms;
	assign result.out_kind    = out_q.out_kind;
	assign result.out_prep_ms = out_q.out_prep_ms;
	assign result.out_target  = out_q.out_target;
	assign result.out_extra   = out_q.out_extra;

	ap_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("second beat accepted while an item is in work");

	ap_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> out_valid_q && $stable(out_q))
		else $error("pending result changed before it was taken");

	ap_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.status <= ST_NONE)
		else $error("result carries an undefined status");

endmodule

@@ tb/sv/esrr_checker.sv @@
// Scoreboard for the expiring-slot round-robin scheduler: watches both channels, keeps
// its own slot table and round-robin pointer, and compares every result beat in order.
// Depends on esrr_pkg, esrr_item_if and esrr_result_if.
`timescale 1ns / 1ps

module esrr_checker (
	input  logic   clk,
	input  logic   arst_n,
	esrr_item_if   item,
	esrr_result_if result,
	output int     fail_count,
	output int     outstanding
);
	import esrr_pkg::*;

	logic        live [SLOT_COUNT];
	slot_t       entry [SLOT_COUNT];
	int unsigned rr_next;
	res_t        awaited_results [$];
	int          mismatches = 0;

	assign fail_count = mismatches;

	// Applies one accepted item to the shadow slot table and returns the reply it earns.
	function automatic res_t schedule_step(input item_t it);
		res_t        r;
		int          slot;
		logic [63:0] end_sum;
		logic [62:0] quot;
		r = '0;
		r.status = ST_NONE;
		case (it.opcode)
			OP_ADD: begin
				slot = -1;
				for (int i = SLOT_COUNT - 1; i >= 0; i--)
					if (!live[i]) slot = i;
				if (slot < 0) begin
					r.status = ST_FULL;
				end else begin
					end_sum = {1'b0, it.now_us} + 64'(it.life_ms) * 64'(US_PER_MS);
					entry[slot].end_time = (end_sum > {1'b0, TIME_MAX}) ? TIME_MAX
						: end_sum[62:0];
					entry[slot].kind   = it.cmd_kind;
					entry[slot].prep   = it.prep_ms;
					entry[slot].target = it.target_bits;
					entry[slot].extra  = it.extra_bytes;
					live[slot] = 1'b1;
					r.status  = ST_ADDED;
					r.slot_no = 4'(slot);
				end
			end
			OP_REMOVE: begin
				if (it.slot_sel < SLOT_COUNT) live[it.slot_sel] = 1'b0;
				r.status = ST_REMOVED;
			end
			OP_TICK: begin
				if (!it.hold) begin
					for (int i = 0; i < SLOT_COUNT; i++)
						if (live[i] && it.now_us >= entry[i].end_time) live[i] = 1'b0;
					slot = -1;
					for (int k = 0; k < SLOT_COUNT; k++)
						if (slot < 0 && live[(rr_next + k) % SLOT_COUNT])
							slot = (rr_next + k) % SLOT_COUNT;
					if (slot >= 0) begin
						rr_next = (slot + 1) % SLOT_COUNT;
						// A slot that survived expiry ends after now, so this cannot wrap.
						quot = (entry[slot].end_time - it.now_us) / 63'(US_PER_MS);
						r.status      = ST_SELECTED;
						r.slot_no     = 4'(slot);
						r.left_ms     = (quot > 63'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
						r.out_kind    = entry[slot].kind;
						r.out_prep_ms = entry[slot].prep;
						r.out_target  = entry[slot].target;
						r.out_extra   = entry[slot].extra;
					end
				end
			end
			default: r.status = ST_NONE;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
	                           input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t  want;
		item_t it;
		if (!arst_n) begin
			foreach (live[i]) live[i] = 1'b0;
			rr_next = 0;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			// The result beat belongs to an earlier item, so it is retired before a
			// new item beat on the same edge is queued.
			if (result.valid && result.ready) begin
				if (awaited_results.size() == 0) begin
					$error("result beat with no expected result pending");
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("status", 64'(want.status), 64'(result.status));
					check_field("slot_no", 64'(want.slot_no), 64'(result.slot_no));
					check_field("left_ms", 64'(want.left_ms), 64'(result.left_ms));
					check_field("out_kind", 64'(want.out_kind), 64'(result.out_kind));
					check_field("out_prep_ms", 64'(want.out_prep_ms),
						64'(result.out_prep_ms));
					check_field("out_target", want.out_target, result.out_target);
					check_field("out_extra", 64'(want.out_extra), 64'(result.out_extra));
				end
			end
			if (item.valid && item.ready) begin
				it.opcode      = op_t'(item.opcode);
				it.now_us      = item.now_us;
				it.hold        = item.hold;
				it.cmd_kind    = item.cmd_kind;
				it.life_ms     = item.life_ms;
				it.prep_ms     = item.prep_ms;
				it.target_bits = item.target_bits;
				it.extra_bytes = item.extra_bytes;
				it.slot_sel    = item.slot_sel;
				awaited_results.push_back(schedule_step(it));
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the scheduler testbench: clock, reset, item and ready stimulus, watchdog
// and verdict. Depends on esrr_pkg, both channel interfaces, the scheduler and esrr_checker.
`timescale 1ns / 1ps

module tb_top;
	import esrr_pkg::*;

	localparam int STALL_LIMIT      = 5000;
	localparam int DRAIN_CYCLES     = 64;
	localparam int HOLDOFF_CYCLES   = 300;
	localparam int RANDOM_PER_PHASE = 560;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	bit          holdoff_req = 1'b0;
	int          fail_count;
	int          outstanding;
	int          quiet_cycles = 0;
	logic [62:0] sim_now = '0;
	int          segment_left = 0;

	esrr_item_if   item_ch ();
	esrr_result_if result_ch ();

	expiring_slot_round_robin_scheduler uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	esrr_checker scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Receiver: random back-pressure, or a long hold-off when one is requested.
	initial begin
		int holdoff_left;
		holdoff_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				holdoff_req = 1'b0;
				holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[expiring_slot_round_robin_scheduler] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic item_t noise_item();
		item_t it;
		it.opcode      = op_t'($urandom_range(3));
		it.now_us      = 63'({$urandom, $urandom});
		it.hold        = 1'($urandom_range(1));
		it.cmd_kind    = 8'($urandom);
		it.life_ms     = $urandom;
		it.prep_ms     = $urandom;
		it.target_bits = {$urandom, $urandom};
		it.extra_bytes = 24'($urandom);
		it.slot_sel    = 8'($urandom);
		return it;
	endfunction

	function automatic item_t add_item(input logic [62:0] now, input logic [31:0] delay);
		item_t it;
		it = noise_item();
		it.opcode  = OP_ADD;
		it.now_us  = now;
		it.life_ms = delay;
		return it;
	endfunction

	function automatic item_t tick_item(input logic [62:0] now, input logic hold);
		item_t it;
		it = noise_item();
		it.opcode = OP_TICK;
		it.now_us = now;
		it.hold   = hold;
		return it;
	endfunction

	function automatic item_t remove_item(input logic [7:0] sel);
		item_t it;
		it = noise_item();
		it.opcode   = OP_REMOVE;
		it.slot_sel = sel;
		return it;
	endfunction

	// Entered and left at a falling edge; valid stays high between back-to-back beats.
	task automatic send_beat(input item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.opcode      <= it.opcode;
		item_ch.now_us      <= it.now_us;
		item_ch.hold        <= it.hold;
		item_ch.cmd_kind    <= it.cmd_kind;
		item_ch.life_ms     <= it.life_ms;
		item_ch.prep_ms     <= it.prep_ms;
		item_ch.target_bits <= it.target_bits;
		item_ch.extra_bytes <= it.extra_bytes;
		item_ch.slot_sel    <= it.slot_sel;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Time runs forward in segments; each segment starts from a fresh base, which may
	// be near the top of the range or behind the previous time.
	task automatic random_beat();
		item_t it;
		int    pick;
		if (segment_left == 0) begin
			segment_left = $urandom_range(40, 150);
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: sim_now = 63'({$urandom_range(255), $urandom});
				6, 7:             sim_now = 63'({$urandom, $urandom});
				8:                sim_now = TIME_MAX - 63'($urandom_range(200000));
				default:          sim_now = sim_now >> $urandom_range(1, 20);
			endcase
		end
		segment_left--;
		pick = $urandom_range(99);
		if (pick < 38) begin
			pick = $urandom_range(99);
			it = add_item(sim_now, (pick < 70) ? 32'($urandom_range(40))
				: (pick < 90) ? 32'($urandom_range(5000)) : $urandom);
		end else if (pick < 55) begin
			it = remove_item(($urandom_range(99) < 85) ? 8'($urandom_range(15))
				: 8'($urandom_range(16, 255)));
		end else if (pick < 95) begin
			it = tick_item(sim_now, $urandom_range(99) < 10);
			if (sim_now < TIME_MAX - 63'd8000) sim_now += 63'($urandom_range(8000));
		end else begin
			it = noise_item();
			it.opcode = OP_RSVD;
		end
		if ($urandom_range(99) < 3) it.now_us = 63'({$urandom, $urandom});
		send_beat(it);
	endtask

	initial begin
		item_t it;
		item_ch.valid       <= 1'b0;
		item_ch.opcode      <= OP_ADD;
		item_ch.now_us      <= '0;
		item_ch.hold        <= 1'b0;
		item_ch.cmd_kind    <= '0;
		item_ch.life_ms     <= '0;
		item_ch.prep_ms     <= '0;
		item_ch.target_bits <= '0;
		item_ch.extra_bytes <= '0;
		item_ch.slot_sel    <= '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Removes of a free slot and of an out-of-range slot, then the unused opcode.
		send_beat(remove_item(8'd0));
		send_beat(remove_item(8'hFF));
		it = noise_item();
		it.opcode = OP_RSVD;
		send_beat(it);
		// A zero lifetime expires on the very tick that shares its time: nothing to pick.
		send_beat(add_item(63'd0, 32'd0));
		send_beat(tick_item(63'd0, 1'b0));
		// End time saturates; seen from time zero the remainder saturates as well.
		it = add_item(TIME_MAX - 63'd5, '1);
		it.cmd_kind    = '1;
		it.prep_ms     = '1;
		it.target_bits = '1;
		it.extra_bytes = '1;
		send_beat(it);
		send_beat(tick_item(63'd0, 1'b1));
		send_beat(tick_item(63'd0, 1'b0));
		// Less than one millisecond left gives a zero remainder.
		it = add_item(63'd0, 32'd1);
		it.cmd_kind    = '0;
		it.prep_ms     = '0;
		it.target_bits = '0;
		it.extra_bytes = '0;
		send_beat(it);
		send_beat(tick_item(63'd999, 1'b0));
		// Fill the remaining slots and run one add past a full table.
		repeat (15) send_beat(add_item(63'd5000, 32'd100000));

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 88 : 0;
			rx_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 20 : 0;
			if (phase == 2) holdoff_req = 1'b1;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) random_beat();
		end
		item_ch.valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("[expiring_slot_round_robin_scheduler] OK");
		end else begin
			$display("[expiring_slot_round_robin_scheduler] ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/esrr_pkg.sv
design/esrr_item_if.sv
design/esrr_result_if.sv
design/esrr_ctrl.sv
design/esrr_dp.sv
design/expiring_slot_round_robin_scheduler.sv
tb/sv/esrr_checker.sv
tb/sv/tb_top.sv
